### rtl/b2da_pkg.sv
`timescale 1ns / 1ps

package b2da_pkg;

  localparam int MAX_DIGITS = 10;
  localparam int VALUE_W    = 32;
  localparam int DIGIT_W    = 4;
  localparam int CHAR_W     = 6;
  // A 32-bit value has at most ten decimal digits.
  localparam int BCD_DIGITS = 10;
  localparam int BCD_W      = BCD_DIGITS * 4;

  localparam logic [CHAR_W-1:0] ASCII_ZERO = CHAR_W'(48);

  typedef logic [3:0] bcd_digit_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [DIGIT_W-1:0] digit_count;
  } req_t;

  typedef struct packed {
    logic [CHAR_W-1:0]  ascii_char;
    logic [DIGIT_W-1:0] digit_index;
    logic               last;
    logic [DIGIT_W-1:0] leading_zeros;
  } rsp_t;

endpackage

### rtl/b2da_dabble.sv
`timescale 1ns / 1ps

module b2da_dabble
  import b2da_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [VALUE_W-1:0]            value,
  output logic                          done,
  output bcd_digit_t [BCD_DIGITS-1:0]   digits
);

  localparam int STEP_W = $clog2(VALUE_W);
  localparam logic [3:0] ADJ_LIMIT = 4'd5;
  localparam logic [3:0] ADJ_ADD   = 4'd3;

  logic                        busy;
  logic [STEP_W-1:0]           cnt;
  logic [VALUE_W-1:0]          bin;
  bcd_digit_t [BCD_DIGITS-1:0] bcd;
  bcd_digit_t [BCD_DIGITS-1:0] adj;
  logic [BCD_W-1:0]            adj_flat;

  // Add-3 correction on every digit before the shift, all digits in parallel.
  always_comb begin
    for (int k = 0; k < BCD_DIGITS; k++) begin
      adj[k] = (bcd[k] >= ADJ_LIMIT) ? bcd[k] + ADJ_ADD : bcd[k];
    end
    adj_flat = adj;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == STEP_W'(VALUE_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      bin <= value;
      bcd <= '0;
    end else if (busy) begin
      bcd <= {adj_flat[BCD_W-2:0], bin[VALUE_W-1]};
      bin <= {bin[VALUE_W-2:0], 1'b0};
    end
  end

  assign digits = bcd;

endmodule

### rtl/binary_to_decimal_ascii.sv
`timescale 1ns / 1ps

// Converts an unsigned 32-bit value into a zero-padded field of ASCII
// decimal characters, most significant position first.
// The request channel (req_valid, req_ready, req) carries the value and the
// field width in digits; a width of zero counts as one, and widths above
// ten count as ten. The response channel (rsp_valid, rsp_ready, rsp) then
// gives one item per digit position, with last set on the final position
// and the count of leading zero positions repeated in every item.
// Each request runs 32 shift-add-3 steps on one shared binary-to-BCD unit,
// then registers the end of the conversion and counts the leading zeros
// in a scan state, then gives one item per cycle while the receiver is
// ready. A new request is taken only after the last item of the current
// one has been accepted; req_ready is high only while the block is idle.
// When the receiver stalls, the current item holds until it is taken.
// Reset returns the block to idle and drops any run in progress.
module binary_to_decimal_ascii
  import b2da_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CONV = 4'b0010,
    S_SCAN = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  state_t                      state;
  logic [DIGIT_W-1:0]          width;
  logic [DIGIT_W-1:0]          width_next;
  logic [DIGIT_W-1:0]          pad;
  logic [DIGIT_W-1:0]          pad_next;
  logic [DIGIT_W-1:0]          ndig;
  logic [DIGIT_W-1:0]          pos;
  logic [DIGIT_W-1:0]          idx;
  logic                        req_take;
  logic                        conv_done;
  bcd_digit_t [BCD_DIGITS-1:0] digits;

  assign req_ready = (state == S_IDLE);
  assign req_take  = req_valid && req_ready;

  b2da_dabble u_dabble (
    .clk    (clk),
    .rst    (rst),
    .start  (req_take),
    .value  (req.value),
    .done   (conv_done),
    .digits (digits)
  );

  always_comb begin
    if (req.digit_count == '0) begin
      width_next = DIGIT_W'(1);
    end else if (req.digit_count > DIGIT_W'(MAX_DIGITS)) begin
      width_next = DIGIT_W'(MAX_DIGITS);
    end else begin
      width_next = req.digit_count;
    end
  end

  // Number of significant decimal digits; zero for a zero value.
  always_comb begin
    ndig = '0;
    for (int k = 0; k < BCD_DIGITS; k++) begin
      if (digits[k] != '0) begin
        ndig = DIGIT_W'(k + 1);
      end
    end
    if (ndig == '0) begin
      pad_next = width - 1'b1;
    end else if (ndig < width) begin
      pad_next = width - ndig;
    end else begin
      pad_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (req_take) begin
            state <= S_CONV;
          end
        end
        S_CONV: begin
          if (conv_done) begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (rsp_ready && pos == '0) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (req_take) begin
      width <= width_next;
    end
    if (state == S_SCAN) begin
      pad <= pad_next;
      pos <= width - 1'b1;
      idx <= '0;
    end else if (state == S_EMIT && rsp_ready) begin
      pos <= pos - 1'b1;
      idx <= idx + 1'b1;
    end
  end

  assign rsp_valid          = (state == S_EMIT);
  assign rsp.ascii_char     = ASCII_ZERO + {{(CHAR_W - 4){1'b0}}, digits[pos]};
  assign rsp.digit_index    = idx;
  assign rsp.last           = (pos == '0);
  assign rsp.leading_zeros  = pad;

  a_state_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot(state))
    else $error("sequencer state is not one-hot");

  a_char_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.ascii_char >= ASCII_ZERO && rsp.ascii_char <= ASCII_ZERO + 6'd9))
    else $error("emitted character is not a decimal digit");

  a_last_index: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.last |-> rsp.digit_index == width - 1'b1)
    else $error("last item at the wrong position");

  a_pad_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.leading_zeros < width)
    else $error("leading zero count not below field width");

  a_done_in_conv: assert property (@(posedge clk) disable iff (rst)
    conv_done |-> state == S_CONV)
    else $error("conversion finished outside the conversion phase");

endmodule

### test/b2da_digit_checker.sv
`timescale 1ns / 1ps

module b2da_digit_checker
  import b2da_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  input  logic req_ready,
  input  req_t req,
  input  logic rsp_valid,
  input  logic rsp_ready,
  input  rsp_t rsp,
  output int   mismatches,
  output int   digits_waiting
);

  rsp_t pending_digits[$];
  rsp_t expected;
  int   error_total = 0;

  // Splits one request into the digit items the block must send, oldest first.
  task automatic expand_digits(input req_t item);
    logic [VALUE_W-1:0] rest;
    bcd_digit_t         digit [MAX_DIGITS];
    int                 width;
    int                 pad;
    rsp_t               r;
    width = int'(item.digit_count);
    if (width < 1) begin
      width = 1;
    end
    if (width > MAX_DIGITS) begin
      width = MAX_DIGITS;
    end
    rest = item.value;
    pad  = 0;
    for (int k = 0; k < MAX_DIGITS; k++) begin
      digit[k] = '0;
    end
    if (rest == '0) begin
      pad = width - 1;
    end else begin
      // Fill from the least significant position; positions left over once
      // the value runs out are padding.
      for (int k = 0; k < width; k++) begin
        if (rest != '0) begin
          digit[width - 1 - k] = bcd_digit_t'(rest % 10);
          rest = rest / 10;
        end else begin
          pad++;
        end
      end
    end
    for (int k = 0; k < width; k++) begin
      r.ascii_char    = ASCII_ZERO + CHAR_W'(digit[k]);
      r.digit_index   = DIGIT_W'(k);
      r.last          = (k == width - 1);
      r.leading_zeros = DIGIT_W'(pad);
      pending_digits.push_back(r);
    end
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && req_ready) begin
        expand_digits(req);
      end
      if (rsp_valid && rsp_ready) begin
        if (pending_digits.size() == 0) begin
          $error("digit item with none expected: ascii_char %0d digit_index %0d",
                 rsp.ascii_char, rsp.digit_index);
          error_total++;
        end else begin
          expected = pending_digits.pop_front();
          if (rsp.ascii_char !== expected.ascii_char) begin
            $error("ascii_char expected %0d got %0d", expected.ascii_char, rsp.ascii_char);
            error_total++;
          end
          if (rsp.digit_index !== expected.digit_index) begin
            $error("digit_index expected %0d got %0d", expected.digit_index,
                   rsp.digit_index);
            error_total++;
          end
          if (rsp.last !== expected.last) begin
            $error("last expected %0d got %0d", expected.last, rsp.last);
            error_total++;
          end
          if (rsp.leading_zeros !== expected.leading_zeros) begin
            $error("leading_zeros expected %0d got %0d", expected.leading_zeros,
                   rsp.leading_zeros);
            error_total++;
          end
        end
      end
    end
    mismatches     <= error_total;
    digits_waiting <= pending_digits.size();
  end

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import b2da_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_START  = 4000;
  localparam int HOLD_LEN    = 400;
  localparam int RANDOM_ITEMS = 400;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req       = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  int mismatches;
  int digits_waiting;
  int burst_left = 0;
  int cycle_total = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  binary_to_decimal_ascii uut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  b2da_digit_checker checker_i (
    .clk            (clk),
    .rst            (rst),
    .req_valid      (req_valid),
    .req_ready      (req_ready),
    .req            (req),
    .rsp_valid      (rsp_valid),
    .rsp_ready      (rsp_ready),
    .rsp            (rsp),
    .mismatches     (mismatches),
    .digits_waiting (digits_waiting)
  );

  // Offers one conversion request and returns at the edge where it is taken.
  // Requests go out in bursts with idle gaps between them.
  task automatic send_conversion(input logic [VALUE_W-1:0] v,
                                 input logic [DIGIT_W-1:0] count);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 8);
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 6);
    end
    burst_left--;
    req_valid <= 1'b1;
    req       <= '{value: v, digit_count: count};
    do @(posedge clk); while (!req_ready);
  endtask

  function automatic logic [VALUE_W-1:0] pick_value();
    logic [VALUE_W-1:0] p;
    int                 n;
    p = 1;
    case ($urandom_range(0, 6))
      0: return '0;
      1: return $urandom_range(0, 999);
      2: return $urandom_range(0, 99999);
      3: begin
        // Decimal boundaries are where the field overflows and padding changes.
        n = $urandom_range(0, 9);
        repeat (n) p = p * 10;
        return $urandom_range(0, 1) ? p : p - 1;
      end
      4: return '1 - VALUE_W'($urandom_range(0, 3));
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [DIGIT_W-1:0] pick_width();
    case ($urandom_range(0, 9))
      0, 1, 2: return DIGIT_W'(3);
      3, 4, 5: return DIGIT_W'(5);
      6, 7:    return DIGIT_W'(10);
      8:       return DIGIT_W'($urandom_range(1, 10));
      default: return DIGIT_W'($urandom_range(0, 15));
    endcase
  endfunction

  // Receiver: switches between always ready, coin-flip and mostly stalled,
  // with one long hold-off that stalls the block and blocks new requests.
  int rx_cycle = 0;
  int rx_mode = 0;
  int rx_mode_left = 0;

  always @(posedge clk) begin
    rx_cycle++;
    if (rx_mode_left == 0) begin
      rx_mode      = $urandom_range(0, 2);
      rx_mode_left = $urandom_range(5, 120);
    end
    rx_mode_left--;
    if (rx_cycle >= HOLD_START && rx_cycle < HOLD_START + HOLD_LEN) begin
      rsp_ready <= 1'b0;
    end else begin
      case (rx_mode)
        0:       rsp_ready <= 1'b1;
        1:       rsp_ready <= $urandom_range(0, 1);
        default: rsp_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    cycle_total++;
    if (cycle_total == CYCLE_LIMIT) begin
      $display("binary_to_decimal_ascii regression: fail");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Zero at several widths, including widths outside the legal range.
    send_conversion(32'd0, 4'd1);
    send_conversion(32'd0, 4'd3);
    send_conversion(32'd0, 4'd5);
    send_conversion(32'd0, 4'd10);
    send_conversion(32'd0, 4'd0);
    send_conversion(32'd0, 4'd15);
    // Full-scale value: fits in ten digits, overflows narrower fields.
    send_conversion(32'hFFFF_FFFF, 4'd10);
    send_conversion(32'hFFFF_FFFF, 4'd3);
    send_conversion(32'hFFFF_FFFF, 4'd1);
    send_conversion(32'hFFFF_FFFF, 4'd15);
    send_conversion(32'hFFFF_FFFF, 4'd11);
    send_conversion(32'd7, 4'd0);
    send_conversion(32'd1, 4'd10);
    send_conversion(32'd9, 4'd1);
    send_conversion(32'd10, 4'd1);
    send_conversion(32'd999, 4'd3);
    send_conversion(32'd1000, 4'd3);
    send_conversion(32'd123, 4'd5);
    send_conversion(32'd99999, 4'd5);
    send_conversion(32'd100000, 4'd5);
    send_conversion(32'd1000000000, 4'd10);
    send_conversion(32'd4000000000, 4'd9);
    send_conversion(32'd5, 4'd12);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      send_conversion(pick_value(), pick_width());
    end

    req_valid <= 1'b0;
    @(posedge clk);
    while (digits_waiting != 0) @(posedge clk);
    repeat (60) @(posedge clk);

    if (mismatches == 0) begin
      $display("binary_to_decimal_ascii regression: pass");
    end else begin
      $display("binary_to_decimal_ascii regression: fail");
    end
    $finish;
  end

endmodule
